// ===== src/met_pkg.sv =====
// Shared types, constants and fixed-point helpers for the escape-time pixel block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package met_pkg;

    localparam int PIXEL_BITS     = 12;
    localparam int FRAC_BITS      = 28;
    localparam int ITER_BITS      = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int STEP_BITS      = 31;
    localparam int QUEUE_DEPTH    = 4;

    localparam int S_TDATA_W = ((2 * PIXEL_BITS + 7) / 8) * 8;
    localparam int M_FIELD_W = ITER_BITS + 2 + 2 * PIXEL_BITS;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    // Coordinates and z are signed fixed point in 32 bits; intermediate sums
    // and products are held exactly in 66 bits before saturation.
    typedef logic signed [31:0] t_fix;
    typedef logic signed [65:0] t_wide;
    typedef logic signed [32:0] t_mop;

    typedef enum logic [1:0] {
        REASON_ESCAPED  = 2'd0,
        REASON_LIMIT    = 2'd1,
        REASON_BULB     = 2'd2,
        REASON_PERIODIC = 2'd3
    } t_reason;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LEFT_REAL         = 3'd0,
        CFG_UPPER_IMAG        = 3'd1,
        CFG_STEP_REAL         = 3'd2,
        CFG_STEP_IMAG         = 3'd3,
        CFG_MAX_ITERATIONS    = 3'd4,
        CFG_ESCAPE_LIMIT      = 3'd5,
        CFG_CHECK_CARDIOID    = 3'd6,
        CFG_CHECK_PERIODICITY = 3'd7
    } t_cfg_index;

    typedef struct packed {
        t_fix                  left_real;
        t_fix                  upper_imag;
        logic [STEP_BITS-1:0]  step_real;
        logic [STEP_BITS-1:0]  step_imag;
        logic [ITER_BITS-1:0]  max_iterations;
        logic [STEP_BITS-1:0]  escape_limit;
        logic                  check_cardioid;
        logic                  check_periodicity;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        left_real:         32'shE000_0000,
        upper_imag:        32'sh1000_0000,
        step_real:         31'd196608,
        step_imag:         31'd196608,
        max_iterations:    16'd256,
        escape_limit:      31'd1073741824,
        check_cardioid:    1'b1,
        check_periodicity: 1'b1
    };

    // One classified pixel on its way from the front end to the iterator.
    typedef struct packed {
        t_fix                  c_re;
        t_fix                  c_im;
        logic [PIXEL_BITS-1:0] px;
        logic [PIXEL_BITS-1:0] py;
        logic                  in_set;
    } t_item;

    typedef struct packed {
        logic [ITER_BITS-1:0]  count;
        t_reason               reason;
        logic [PIXEL_BITS-1:0] x;
        logic [PIXEL_BITS-1:0] y;
    } t_result;

    typedef enum logic [3:0] {
        F_IDLE,
        F_MAP_RE,
        F_MAP_IM,
        F_SPLIT,
        F_SQ_Y,
        F_SQ_A,
        F_SQ_B,
        F_SUM,
        F_QA,
        F_MUL_Q,
        F_CMP,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_STEP,
        B_WAIT
    } t_back_state;

    localparam t_fix FIX_MAX = 32'sh7FFF_FFFF;
    localparam t_fix FIX_MIN = 32'sh8000_0000;

    function automatic t_wide wide(input t_fix v);
        return t_wide'(v);
    endfunction

    function automatic t_fix sat32(input t_wide v);
        t_fix r;
        if (v > wide(FIX_MAX)) begin
            r = FIX_MAX;
        end else if (v < wide(FIX_MIN)) begin
            r = FIX_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Product rescaled to the fixed-point grid, floor rounding, then saturated.
    function automatic t_fix fx_scale(input t_wide prod);
        t_wide s;
        s = prod >>> FRAC_BITS;
        return sat32(s);
    endfunction

    localparam t_fix FX_ONE       = sat32(t_wide'(1) <<< FRAC_BITS);
    localparam t_fix FX_QUARTER   = sat32(t_wide'(1) <<< (FRAC_BITS - 2));
    localparam t_fix FX_SIXTEENTH = sat32(t_wide'(1) <<< (FRAC_BITS - 4));

endpackage

`default_nettype wire

// ===== src/mandelbrot_escape_time_pixel_top.sv =====
// Top level of the escape-time pixel block: configuration registers, front
// end, queue and iterator. Depends on met_pkg, met_front, met_fifo, met_back.
//
// Usage: pixels enter on the s_axis channel, one word per pixel, and each
// produces exactly one result word on m_axis, in order. Configuration is a
// plain write port (i_cfg_we, i_cfg_index, i_cfg_data), written while idle.
// The front end takes a pixel, then forms c and runs the cardioid and bulb
// test on its single shared multiplier (it only forms c when the test is
// off) before the pixel enters the queue. The iterator spends each iteration
// on a multiply step, then an update and test step, plus setup, final test
// and hand-off per pixel. Points caught by the cardioid and bulb test skip
// the iteration loop.
// The iteration loop sets the sustained rate; the queue lets the front end
// classify further pixels meanwhile. A stalled receiver holds the result in
// the output register; the iterator finishes its next pixel and waits, and
// the queue and front end keep filling until full, then s_axis_tready drops.
// Reset restores all configuration registers and empties every stage.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time_pixel_top #(
    parameter int QUEUE_DEPTH = met_pkg::QUEUE_DEPTH
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [met_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire [met_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // pixel_x, pixel_y
    input  wire [met_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // iteration_count, end_reason, out_x, out_y, zero padding
    output logic [met_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

    met_pkg::t_cfg    r_cfg;
    met_pkg::t_item   w_front_item, w_queue_item;
    met_pkg::t_result w_result;
    logic             w_push, w_full, w_queue_valid, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= met_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (met_pkg::t_cfg_index'(i_cfg_index))
                met_pkg::CFG_LEFT_REAL:         r_cfg.left_real  <= i_cfg_data;
                met_pkg::CFG_UPPER_IMAG:        r_cfg.upper_imag <= i_cfg_data;
                met_pkg::CFG_STEP_REAL:
                    r_cfg.step_real <= i_cfg_data[met_pkg::STEP_BITS-1:0];
                met_pkg::CFG_STEP_IMAG:
                    r_cfg.step_imag <= i_cfg_data[met_pkg::STEP_BITS-1:0];
                met_pkg::CFG_MAX_ITERATIONS:
                    r_cfg.max_iterations <= i_cfg_data[met_pkg::ITER_BITS-1:0];
                met_pkg::CFG_ESCAPE_LIMIT:
                    r_cfg.escape_limit <= i_cfg_data[met_pkg::STEP_BITS-1:0];
                met_pkg::CFG_CHECK_CARDIOID:    r_cfg.check_cardioid    <= i_cfg_data[0];
                met_pkg::CFG_CHECK_PERIODICITY: r_cfg.check_periodicity <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    met_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_px    (s_axis_tdata[met_pkg::PIXEL_BITS-1:0]),
        .i_py    (s_axis_tdata[2*met_pkg::PIXEL_BITS-1:met_pkg::PIXEL_BITS]),
        .o_push  (w_push),
        .o_item  (w_front_item),
        .i_full  (w_full)
    );

    met_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .o_valid (w_queue_valid),
        .i_pop   (w_pop),
        .o_item  (w_queue_item)
    );

    met_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_queue_valid),
        .o_pop    (w_pop),
        .i_item   (w_queue_item),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = {{met_pkg::M_PAD_W{1'b0}}, w_result.y, w_result.x,
                           w_result.reason, w_result.count};

endmodule

`default_nettype wire

// ===== src/met_front.sv =====
// Front end: maps a pixel to c and, if enabled, runs the cardioid/bulb test.
// One shared multiplier is stepped by a small sequencer; depends on met_pkg.
`timescale 1ns / 1ps
`default_nettype none

module met_front (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  met_pkg::t_cfg                  i_cfg,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire [met_pkg::PIXEL_BITS-1:0]  i_px,
    input  wire [met_pkg::PIXEL_BITS-1:0]  i_py,
    output logic                           o_push,
    output met_pkg::t_item                 o_item,
    input  wire                            i_full
);

    met_pkg::t_front_state r_state, n_state;

    logic [met_pkg::PIXEL_BITS-1:0] r_px, r_py;
    met_pkg::t_wide r_prod;
    met_pkg::t_fix  r_cr, r_ci, r_a, r_b, r_y2, r_aa, r_q, r_qa;
    logic           r_bulb, r_in_set;

    met_pkg::t_mop  w_mul_a, w_mul_b;
    met_pkg::t_wide w_prod;

    assign w_prod = w_mul_a * w_mul_b;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            met_pkg::F_IDLE:   if (i_valid) n_state = met_pkg::F_MAP_RE;
            met_pkg::F_MAP_RE: n_state = met_pkg::F_MAP_IM;
            met_pkg::F_MAP_IM: n_state = met_pkg::F_SPLIT;
            met_pkg::F_SPLIT: begin
                n_state = i_cfg.check_cardioid ? met_pkg::F_SQ_Y : met_pkg::F_PUSH;
            end
            met_pkg::F_SQ_Y:   n_state = met_pkg::F_SQ_A;
            met_pkg::F_SQ_A:   n_state = met_pkg::F_SQ_B;
            met_pkg::F_SQ_B:   n_state = met_pkg::F_SUM;
            met_pkg::F_SUM:    n_state = met_pkg::F_QA;
            met_pkg::F_QA:     n_state = met_pkg::F_MUL_Q;
            met_pkg::F_MUL_Q:  n_state = met_pkg::F_CMP;
            met_pkg::F_CMP:    n_state = met_pkg::F_PUSH;
            met_pkg::F_PUSH:   if (!i_full) n_state = met_pkg::F_IDLE;
            default:           n_state = met_pkg::F_IDLE;
        endcase
    end

    // Handshakes and multiplier operand selection.
    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            met_pkg::F_IDLE: o_ready = 1'b1;
            met_pkg::F_MAP_RE: begin
                w_mul_a = met_pkg::t_mop'(r_px);
                w_mul_b = met_pkg::t_mop'(i_cfg.step_real);
            end
            met_pkg::F_MAP_IM: begin
                w_mul_a = met_pkg::t_mop'(r_py);
                w_mul_b = met_pkg::t_mop'(i_cfg.step_imag);
            end
            met_pkg::F_SQ_Y: begin
                w_mul_a = met_pkg::t_mop'(r_ci);
                w_mul_b = met_pkg::t_mop'(r_ci);
            end
            met_pkg::F_SQ_A: begin
                w_mul_a = met_pkg::t_mop'(r_a);
                w_mul_b = met_pkg::t_mop'(r_a);
            end
            met_pkg::F_SQ_B: begin
                w_mul_a = met_pkg::t_mop'(r_b);
                w_mul_b = met_pkg::t_mop'(r_b);
            end
            met_pkg::F_MUL_Q: begin
                w_mul_a = met_pkg::t_mop'(r_q);
                w_mul_b = met_pkg::t_mop'(r_qa);
            end
            met_pkg::F_PUSH: o_push = !i_full;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= met_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath. The product register always follows the multiplier; each step
    // consumes the product that the previous step selected.
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        unique case (r_state)
            met_pkg::F_IDLE: begin
                r_px <= i_px;
                r_py <= i_py;
            end
            met_pkg::F_MAP_IM: begin
                r_cr <= met_pkg::sat32(met_pkg::wide(i_cfg.left_real) + r_prod);
            end
            met_pkg::F_SPLIT: begin
                r_ci     <= met_pkg::sat32(met_pkg::wide(i_cfg.upper_imag) - r_prod);
                r_a      <= met_pkg::sat32(met_pkg::wide(r_cr)
                                           - met_pkg::wide(met_pkg::FX_QUARTER));
                r_b      <= met_pkg::sat32(met_pkg::wide(r_cr)
                                           + met_pkg::wide(met_pkg::FX_ONE));
                r_in_set <= 1'b0;
            end
            met_pkg::F_SQ_A: r_y2 <= met_pkg::fx_scale(r_prod);
            met_pkg::F_SQ_B: r_aa <= met_pkg::fx_scale(r_prod);
            met_pkg::F_SUM: begin
                r_q    <= met_pkg::sat32(met_pkg::wide(r_aa) + met_pkg::wide(r_y2));
                r_bulb <= met_pkg::sat32(met_pkg::wide(met_pkg::fx_scale(r_prod))
                                         + met_pkg::wide(r_y2)) < met_pkg::FX_SIXTEENTH;
            end
            met_pkg::F_QA: begin
                r_qa <= met_pkg::sat32(met_pkg::wide(r_q) + met_pkg::wide(r_a));
            end
            met_pkg::F_CMP: begin
                r_in_set <= (met_pkg::fx_scale(r_prod) < (r_y2 >>> 2)) || r_bulb;
            end
            default: ;
        endcase
    end

    assign o_item = '{c_re: r_cr, c_im: r_ci, px: r_px, py: r_py, in_set: r_in_set};

endmodule

`default_nettype wire

// ===== src/met_fifo.sv =====
// Short queue of classified pixels between the front end and the iterator.
// Register array with wrap-around pointers; depends on met_pkg.
`timescale 1ns / 1ps
`default_nettype none

module met_fifo #(
    parameter int DEPTH = met_pkg::QUEUE_DEPTH
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  met_pkg::t_item  i_item,
    output logic            o_full,
    output logic            o_valid,
    input  wire             i_pop,
    output met_pkg::t_item  o_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    met_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/met_back.sv =====
// Back end: iterates z = z*z + c for one queued pixel and holds the result
// in an output register. Three multipliers feed one update step; needs met_pkg.
`timescale 1ns / 1ps
`default_nettype none

module met_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  met_pkg::t_cfg      i_cfg,
    input  wire                i_valid,
    output logic               o_pop,
    input  met_pkg::t_item     i_item,
    output logic               o_valid,
    input  wire                i_ready,
    output met_pkg::t_result   o_result
);

    met_pkg::t_back_state r_state, n_state;

    met_pkg::t_fix  r_cr, r_ci, r_zr, r_zi;
    met_pkg::t_wide r_p_rr, r_p_ii, r_p_ri;
    logic [met_pkg::ITER_BITS-1:0]  r_n;
    logic [met_pkg::PIXEL_BITS-1:0] r_px, r_py;
    logic [met_pkg::ITER_BITS-1:0]  r_res_count;
    met_pkg::t_reason               r_res_reason;
    logic                           r_out_valid;
    met_pkg::t_result               r_out;

    met_pkg::t_wide w_p_rr, w_p_ii, w_p_ri;
    met_pkg::t_fix  w_xx, w_yy, w_mag, w_nr, w_ni, w_escape;
    logic           w_at_limit, w_stop, w_repeat, w_load;

    assign w_p_rr = r_zr * r_zr;
    assign w_p_ii = r_zi * r_zi;
    assign w_p_ri = r_zr * r_zi;

    assign w_xx       = met_pkg::fx_scale(r_p_rr);
    assign w_yy       = met_pkg::fx_scale(r_p_ii);
    assign w_mag      = met_pkg::sat32(met_pkg::wide(w_xx) + met_pkg::wide(w_yy));
    assign w_escape   = met_pkg::t_fix'(i_cfg.escape_limit);
    assign w_at_limit = (r_n >= i_cfg.max_iterations);
    assign w_stop     = (w_mag >= w_escape) || w_at_limit;
    assign w_nr       = met_pkg::sat32(met_pkg::wide(w_xx) - met_pkg::wide(w_yy)
                                       + met_pkg::wide(r_cr));
    // 2*zr*zi keeps one more fraction bit of the exact product.
    assign w_ni       = met_pkg::sat32((r_p_ri >>> (met_pkg::FRAC_BITS - 1))
                                       + met_pkg::wide(r_ci));
    assign w_repeat   = i_cfg.check_periodicity && (w_nr == r_zr) && (w_ni == r_zi);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            met_pkg::B_IDLE: begin
                if (i_valid) begin
                    n_state = i_item.in_set ? met_pkg::B_WAIT : met_pkg::B_MUL;
                end
            end
            met_pkg::B_MUL:  n_state = met_pkg::B_STEP;
            met_pkg::B_STEP: begin
                n_state = (w_stop || w_repeat) ? met_pkg::B_WAIT : met_pkg::B_MUL;
            end
            met_pkg::B_WAIT: begin
                if (!r_out_valid || i_ready) n_state = met_pkg::B_IDLE;
            end
            default: n_state = met_pkg::B_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        unique case (r_state)
            met_pkg::B_IDLE: o_pop  = i_valid;
            met_pkg::B_WAIT: w_load = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= met_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            met_pkg::B_IDLE: begin
                r_cr         <= i_item.c_re;
                r_ci         <= i_item.c_im;
                r_px         <= i_item.px;
                r_py         <= i_item.py;
                r_zr         <= '0;
                r_zi         <= '0;
                r_n          <= '0;
                r_res_count  <= i_cfg.max_iterations;
                r_res_reason <= met_pkg::REASON_BULB;
            end
            met_pkg::B_MUL: begin
                r_p_rr <= w_p_rr;
                r_p_ii <= w_p_ii;
                r_p_ri <= w_p_ri;
            end
            met_pkg::B_STEP: begin
                if (w_stop) begin
                    r_res_count  <= r_n;
                    r_res_reason <= w_at_limit ? met_pkg::REASON_LIMIT
                                               : met_pkg::REASON_ESCAPED;
                end else if (w_repeat) begin
                    r_res_count  <= i_cfg.max_iterations;
                    r_res_reason <= met_pkg::REASON_PERIODIC;
                end else begin
                    r_zr <= w_nr;
                    r_zi <= w_ni;
                    r_n  <= r_n + 1'b1;
                end
            end
            default: ;
        endcase
        if (w_load) begin
            r_out <= '{count: r_res_count, reason: r_res_reason, x: r_px, y: r_py};
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ===== src/met_checker.sv =====
// Port-level checks for the escape-time pixel block, bound to its top level.
// Depends on met_pkg and mandelbrot_escape_time_pixel_top.
`timescale 1ns / 1ps
`default_nettype none

module met_checker (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    input  wire                               s_axis_tready,
    input  wire                               m_axis_tvalid,
    input  wire                               m_axis_tready,
    input  wire [met_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    // Words accepted but not yet delivered.
    logic [7:0] r_pending;
    logic       w_in_acc, w_out_acc;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_pending <= r_pending + 1'b1;
        end else if (w_out_acc && !w_in_acc) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed or dropped while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != 8'd0)
        else $error("result word presented with no pixel outstanding");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind mandelbrot_escape_time_pixel_top met_checker u_met_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== test/mandelbrot_escape_time_pixel_top_tb.sv =====
// Self-checking testbench for the escape-time pixel block: drives pixel words,
// predicts each result in fixed point and checks it. Depends on met_pkg and the top.
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_top_tb;
    import met_pkg::*;

    localparam int     FRAC        = FRAC_BITS;
    localparam longint FX_HI       = 64'sd2147483647;
    localparam longint FX_LO       = -64'sd2147483648;
    localparam longint FX_1        = 64'sd1 <<< FRAC;
    localparam longint FX_QUARTER  = 64'sd1 <<< (FRAC - 2);
    localparam longint FX_16TH     = 64'sd1 <<< (FRAC - 4);
    localparam int     RSN_LO      = ITER_BITS;
    localparam int     X_LO        = ITER_BITS + 2;
    localparam int     Y_LO        = X_LO + PIXEL_BITS;
    localparam int     PHASES      = 12;
    localparam int     PHASE_ITEMS = 107;
    localparam int     HOLD_CYCLES = 3000;
    localparam int     QUIET_LIMIT = 20000;
    localparam int     SETTLE      = 8;

    typedef logic [7:0][31:0] t_view;

    typedef struct packed {
        bit                    is_view;
        t_view                 view;
        logic [PIXEL_BITS-1:0] px;
        logic [PIXEL_BITS-1:0] py;
        bit                    typed;
        t_result               known;
    } t_probe;

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_cfg_we      = 1'b0;
    logic [CFG_INDEX_BITS-1:0]    i_cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]     i_cfg_data    = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [S_TDATA_W-1:0]         s_axis_tdata  = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]         m_axis_tdata;

    // Shadow of the view registers, as the block should hold them.
    longint      view_left    = -64'sd536870912;
    longint      view_top     = 64'sd268435456;
    longint      view_step_x  = 64'sd196608;
    longint      view_step_y  = 64'sd196608;
    int unsigned iter_limit   = 256;
    longint      escape_bound = 64'sd1073741824;
    bit          cardioid_on  = 1'b1;
    bit          period_on    = 1'b1;

    t_result pixel_results_due[$];
    t_probe  probes[$];
    int      mismatches   = 0;
    int      quiet_cycles = 0;
    int      stall_left   = 0;
    logic    steady       = 1'b0;
    logic    hold_ask     = 1'b0;
    logic    hold_taken   = 1'b0;

    mandelbrot_escape_time_pixel_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint fix_sat(input longint v);
        if (v > FX_HI) return FX_HI;
        if (v < FX_LO) return FX_LO;
        return v;
    endfunction

    function automatic longint fix_mul(input longint a, input longint b);
        return fix_sat((a * b) >>> FRAC);
    endfunction

    function automatic t_result escape_time(input logic [PIXEL_BITS-1:0] px,
                                            input logic [PIXEL_BITS-1:0] py);
        t_result     r;
        longint      cr, ci, zr, zi, xx, yy, nr, ni, y2, a, q, b;
        int unsigned n;
        bit          running;
        r.x = px;
        r.y = py;
        cr = fix_sat(view_left + longint'(px) * view_step_x);
        ci = fix_sat(view_top - longint'(py) * view_step_y);
        if (cardioid_on) begin
            y2 = fix_mul(ci, ci);
            a  = fix_sat(cr - FX_QUARTER);
            q  = fix_sat(fix_mul(a, a) + y2);
            b  = fix_sat(cr + FX_1);
            if (fix_mul(q, fix_sat(q + a)) < (y2 >>> 2) ||
                fix_sat(fix_mul(b, b) + y2) < FX_16TH) begin
                r.count  = iter_limit[ITER_BITS-1:0];
                r.reason = REASON_BULB;
                return r;
            end
        end
        zr = 0;
        zi = 0;
        n  = 0;
        running = 1'b1;
        while (running) begin
            xx = fix_mul(zr, zr);
            yy = fix_mul(zi, zi);
            if (fix_sat(xx + yy) >= escape_bound || n >= iter_limit) begin
                running = 1'b0;
            end else begin
                nr = fix_sat(xx - yy + cr);
                ni = fix_sat(((zr * zi) >>> (FRAC - 1)) + ci);
                if (period_on && nr == zr && ni == zi) begin
                    r.count  = iter_limit[ITER_BITS-1:0];
                    r.reason = REASON_PERIODIC;
                    return r;
                end
                zr = nr;
                zi = ni;
                n++;
            end
        end
        r.count  = n[ITER_BITS-1:0];
        r.reason = (n >= iter_limit) ? REASON_LIMIT : REASON_ESCAPED;
        return r;
    endfunction

    function automatic t_view view_words(input logic [31:0] left, input logic [31:0] top,
                                         input logic [31:0] sx, input logic [31:0] sy,
                                         input logic [31:0] maxit, input logic [31:0] esc,
                                         input logic [31:0] card, input logic [31:0] per);
        t_view w;
        w[CFG_LEFT_REAL]         = left;
        w[CFG_UPPER_IMAG]        = top;
        w[CFG_STEP_REAL]         = sx;
        w[CFG_STEP_IMAG]         = sy;
        w[CFG_MAX_ITERATIONS]    = maxit;
        w[CFG_ESCAPE_LIMIT]      = esc;
        w[CFG_CHECK_CARDIOID]    = card;
        w[CFG_CHECK_PERIODICITY] = per;
        return w;
    endfunction

    function automatic t_result known_result(input int count, input t_reason reason,
                                             input int px, input int py);
        t_result r;
        r.count  = count[ITER_BITS-1:0];
        r.reason = reason;
        r.x      = px[PIXEL_BITS-1:0];
        r.y      = py[PIXEL_BITS-1:0];
        return r;
    endfunction

    task automatic add_view(input t_view w);
        t_probe p;
        p = '0;
        p.is_view = 1'b1;
        p.view = w;
        probes.push_back(p);
    endtask

    task automatic add_pixel(input int px, input int py);
        t_probe p;
        p = '0;
        p.px = px[PIXEL_BITS-1:0];
        p.py = py[PIXEL_BITS-1:0];
        probes.push_back(p);
    endtask

    task automatic add_known(input int px, input int py, input int count,
                             input t_reason reason);
        t_probe p;
        p = '0;
        p.px = px[PIXEL_BITS-1:0];
        p.py = py[PIXEL_BITS-1:0];
        p.typed = 1'b1;
        p.known = known_result(count, reason, px, py);
        probes.push_back(p);
    endtask

    // Drains the block, then writes all eight view registers back to back.
    task automatic apply_view(input t_view w);
        logic [31:0] v;
        s_axis_tvalid <= 1'b0;
        while (pixel_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        for (int i = 0; i < 8; i++) begin
            v = w[i];
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i[CFG_INDEX_BITS-1:0];
            i_cfg_data  <= v;
            @(posedge i_clk);
            case (t_cfg_index'(i))
                CFG_LEFT_REAL:         view_left    = longint'($signed(v));
                CFG_UPPER_IMAG:        view_top     = longint'($signed(v));
                CFG_STEP_REAL:         view_step_x  = longint'(v[30:0]);
                CFG_STEP_IMAG:         view_step_y  = longint'(v[30:0]);
                CFG_MAX_ITERATIONS:    iter_limit   = v[15:0];
                CFG_ESCAPE_LIMIT:      escape_bound = longint'(v[30:0]);
                CFG_CHECK_CARDIOID:    cardioid_on  = v[0];
                CFG_CHECK_PERIODICITY: period_on    = v[0];
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    // Offers one pixel word and records its result once the word is taken.
    task automatic send_pixel(input logic [PIXEL_BITS-1:0] px,
                              input logic [PIXEL_BITS-1:0] py,
                              input bit typed, input t_result known);
        while (!steady && $urandom_range(99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pixel_results_due.push_back(typed ? known : escape_time(px, py));
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_ask && !hold_taken) begin
            hold_taken    <= 1'b1;
            stall_left    <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge i_clk) begin : check_result
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.count  = m_axis_tdata[RSN_LO-1:0];
            got.reason = t_reason'(m_axis_tdata[X_LO-1:RSN_LO]);
            got.x      = m_axis_tdata[Y_LO-1:X_LO];
            got.y      = m_axis_tdata[Y_LO+PIXEL_BITS-1:Y_LO];
            if (pixel_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word: count %0d reason %0d x %0d y %0d",
                             got.count, got.reason, got.x, got.y);
                end
            end else begin
                want = pixel_results_due.pop_front();
                if (got.count !== want.count || got.reason !== want.reason ||
                    got.x !== want.x || got.y !== want.y) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch (count/reason/x/y): want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.count, want.reason, want.x, want.y,
                                 got.count, got.reason, got.x, got.y);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_view   w;
        t_probe  p;
        int      k;
        longint  step, cre, cim;
        logic [31:0] esc;
        t_view   home;

        home = view_words(32'hE000_0000, 32'h1000_0000, 196608, 196608, 256,
                          32'h4000_0000, 1, 1);

        // Reset view: corners of the frame, a point near zero and one near -1.
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_pixel(4095, 0);
        add_pixel(0, 4095);
        add_known(2731, 1365, 256, REASON_BULB);
        add_known(1365, 1365, 256, REASON_BULB);
        // Shortcut off: the same points have to be iterated.
        add_view(view_words(32'hE000_0000, 32'h1000_0000, 196608, 196608, 256,
                            32'h4000_0000, 0, 1));
        add_pixel(2731, 1365);
        add_pixel(1365, 1365);
        // c at the origin: z never moves, so it repeats at once or runs out.
        add_view(view_words(0, 0, 196608, 196608, 300, 32'h4000_0000, 0, 1));
        add_known(0, 0, 300, REASON_PERIODIC);
        add_view(view_words(0, 0, 196608, 196608, 300, 32'h4000_0000, 0, 0));
        add_known(0, 0, 300, REASON_LIMIT);
        add_pixel(100, 100);
        // Zero iteration limit, then zero escape bound.
        add_view(view_words(0, 0, 196608, 196608, 0, 32'h4000_0000, 0, 1));
        add_known(0, 0, 0, REASON_LIMIT);
        add_known(4095, 4095, 0, REASON_LIMIT);
        add_view(view_words(0, 0, 196608, 196608, 256, 0, 0, 1));
        add_known(0, 0, 0, REASON_ESCAPED);
        add_known(4095, 4095, 0, REASON_ESCAPED);
        // Largest iteration limit, only on points that end quickly.
        add_view(view_words(0, 0, 196608, 196608, 65535, 32'h4000_0000, 1, 1));
        add_known(0, 0, 65535, REASON_BULB);
        add_pixel(4095, 0);
        // Saturating coordinates; the upper write bits must be dropped.
        add_view(view_words(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_pixel(4095, 4095);
        add_pixel(0, 0);
        add_pixel(1, 1);
        add_view(view_words(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 16, 32'h7FFF_FFFF, 0, 0));
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_view(view_words(32'hE000_0000, 32'h1000_0000, 196608, 196608, 1,
                            32'h4000_0000, 0, 1));
        add_pixel(2731, 1365);
        add_pixel(2048, 2048);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probes[i]) begin
            p = probes[i];
            if (p.is_view) begin
                apply_view(p.view);
            end else begin
                send_pixel(p.px, p.py, p.typed, p.known);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 4 || ph == 10) begin
                // Noise: arbitrary register words, short iteration limit.
                w = view_words($urandom, $urandom, $urandom, $urandom,
                               {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 64))},
                               $urandom, $urandom, $urandom);
            end else begin
                // A random window of the interesting region, at a random zoom.
                k    = $urandom_range(0, 9);
                step = (longint'(196608) >>> k) + $urandom_range(0, 63);
                cre  = longint'($urandom_range(0, 751619276)) - 590558003;
                cim  = longint'($urandom_range(0, 697932186)) - 348966093;
                esc  = ($urandom_range(0, 3) == 0) ? $urandom_range(32'h0400_0000, 32'h7FFF_FFFF)
                                                  : 32'h4000_0000;
                w = view_words(32'(cre - 2048 * step), 32'(cim + 2048 * step),
                               32'(step) | ($urandom_range(0, 1) << 31),
                               32'(step) | ($urandom_range(0, 1) << 31),
                               (ph == 9) ? 256 : $urandom_range(8, 96),
                               esc | ($urandom_range(0, 1) << 31),
                               $urandom_range(0, 1), $urandom_range(0, 1));
            end
            if (ph == 2) begin
                w = home;
            end
            apply_view(w);
            if (ph == 3) begin
                steady <= 1'b1;
            end
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                if (ph == 5 && j == 20) begin
                    hold_ask <= 1'b1;
                end
                if (ph == 7 && j == 50) begin
                    s_axis_tvalid <= 1'b0;
                    while (pixel_results_due.size() != 0) @(posedge i_clk);
                end
                send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0, '0);
            end
            if (ph == 3) begin
                steady <= 1'b0;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pixel_results_due.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (mismatches == 0 && pixel_results_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
